### sv/qxmm_pkg.sv
`timescale 1ns / 1ps

package qxmm_pkg;

   // Fixed point format of the command fields.
   localparam int INPUT_FRAC_BITS = 10;

   localparam int CMD_W  = 20;
   localparam int CODE_W = 16;
   localparam int LANES  = 4;

   // Four 20-bit commands summed need two more bits.
   localparam int SUM_W = CMD_W + 2;
   localparam int MAG_W = SUM_W;
   localparam int POS_W = SUM_W - 1;
   localparam int NUM_W = POS_W + CODE_W;
   localparam int Q_W   = CODE_W;

   // Quotient pipeline: two quotient bits are resolved in each stage.
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

   // Sum, maximum, multiply, divider stages and the output register.
   localparam int PIPE_LATENCY = DIV_STAGES + 4;

   localparam logic [MAG_W-1:0] ONE_CODE = MAG_W'(1) << INPUT_FRAC_BITS;

   // Register map.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_MINIMUM = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_MAXIMUM = CSR_INDEX_W'(1);

   localparam logic [CODE_W-1:0] RESET_OUTPUT_MINIMUM = CODE_W'(1000);
   localparam logic [CODE_W-1:0] RESET_OUTPUT_MAXIMUM = CODE_W'(2000);

   // Lane order of the motor sums.
   localparam int LANE_FRONT_RIGHT = 0;
   localparam int LANE_FRONT_LEFT  = 1;
   localparam int LANE_REAR_LEFT   = 2;
   localparam int LANE_REAR_RIGHT  = 3;

   typedef struct packed {
      logic signed [CMD_W-1:0] throttle_cmd;
      logic signed [CMD_W-1:0] roll_cmd;
      logic signed [CMD_W-1:0] pitch_cmd;
      logic signed [CMD_W-1:0] yaw_cmd;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] motor_front_right;
      logic [CODE_W-1:0] motor_front_left;
      logic [CODE_W-1:0] motor_rear_left;
      logic [CODE_W-1:0] motor_rear_right;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] output_minimum;
      logic [CODE_W-1:0] output_maximum;
   } cfg_type;

   // Positive parts of the sums and the normalizing denominator.
   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][POS_W-1:0] s_pos;
      logic [MAG_W-1:0]            den;
   } mix_type;

   // Partial remainders and numerator/quotient shift words of the divider.
   typedef struct packed {
      logic                        valid;
      logic [LANES-1:0][MAG_W-1:0] rem;
      logic [LANES-1:0][Q_W-1:0]   work;
      logic [MAG_W-1:0]            den;
   } div_type;

endpackage

### sv/qxmm_csr.sv
`timescale 1ns / 1ps

module qxmm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qxmm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qxmm_pkg::CODE_W-1:0]      csr_wdata,
   output qxmm_pkg::cfg_type                cfg
);
   import qxmm_pkg::*;

   cfg_type cfg_in;
   cfg_type cfg_ff;

   // Writes are taken whenever the block is out of reset.
   assign csr_ready = !reset;

   // Decode the register index; other indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OUTPUT_MINIMUM: cfg_in.output_minimum = csr_wdata;
            CSR_OUTPUT_MAXIMUM: cfg_in.output_maximum = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_minimum <= RESET_OUTPUT_MINIMUM;
         cfg_ff.output_maximum <= RESET_OUTPUT_MAXIMUM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/qxmm_mixer.sv
`timescale 1ns / 1ps

module qxmm_mixer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  qxmm_pkg::req_type req_data,
   output qxmm_pkg::mix_type mix
);
   import qxmm_pkg::*;

   logic                               sum_valid_in;
   logic                               sum_valid_ff;
   logic [LANES-1:0][SUM_W-1:0]        sum_in;
   logic [LANES-1:0][SUM_W-1:0]        sum_ff;
   logic [LANES-1:0][MAG_W-1:0]        mag;
   logic [MAG_W-1:0]                   max_a;
   logic [MAG_W-1:0]                   max_b;
   logic [MAG_W-1:0]                   max_all;
   mix_type                            mix_in;
   mix_type                            mix_ff;

   // Quad-X mixing of the four commands.
   always_comb begin : mix_sums
      logic signed [SUM_W-1:0] t;
      logic signed [SUM_W-1:0] r;
      logic signed [SUM_W-1:0] p;
      logic signed [SUM_W-1:0] y;
      t = SUM_W'(req_data.throttle_cmd);
      r = SUM_W'(req_data.roll_cmd);
      p = SUM_W'(req_data.pitch_cmd);
      y = SUM_W'(req_data.yaw_cmd);
      sum_in[LANE_FRONT_RIGHT] = t + r - p + y;
      sum_in[LANE_FRONT_LEFT]  = t - r - p - y;
      sum_in[LANE_REAR_LEFT]   = t - r + p + y;
      sum_in[LANE_REAR_RIGHT]  = t + r + p - y;
      sum_valid_in             = in_valid;
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   // Magnitudes and their maximum through a two-level compare tree.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag[l] = sum_ff[l][SUM_W-1] ? (~sum_ff[l] + MAG_W'(1)) : sum_ff[l];
      end
      max_a   = (mag[0] > mag[1]) ? mag[0] : mag[1];
      max_b   = (mag[2] > mag[3]) ? mag[2] : mag[3];
      max_all = (max_a > max_b) ? max_a : max_b;
   end

   // Scale only when the largest magnitude passes full scale; sums at or
   // below zero drive nothing.
   always_comb begin
      mix_in.valid = sum_valid_ff;
      mix_in.den   = (max_all > ONE_CODE) ? max_all : ONE_CODE;
      for (int l = 0; l < LANES; l++) begin
         if (sum_ff[l][SUM_W-1] || (sum_ff[l] == '0)) begin
            mix_in.s_pos[l] = '0;
         end else begin
            mix_in.s_pos[l] = sum_ff[l][POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff <= '0;
      end else begin
         mix_ff <= mix_in;
      end
   end

   assign mix = mix_ff;

endmodule

### sv/qxmm_scale.sv
`timescale 1ns / 1ps

module qxmm_scale (
   input  logic              clock,
   input  logic              reset,
   input  qxmm_pkg::cfg_type cfg,
   input  qxmm_pkg::mix_type mix,
   output qxmm_pkg::div_type div_out
);
   import qxmm_pkg::*;

   logic [CODE_W-1:0] span;
   div_type           div_in;
   div_type           div_ff;

   // Distance between the two output limits, in either direction.
   always_comb begin
      if (cfg.output_maximum >= cfg.output_minimum) begin
         span = cfg.output_maximum - cfg.output_minimum;
      end else begin
         span = cfg.output_minimum - cfg.output_maximum;
      end
   end

   // One multiply per lane; the product seeds the divider. Its upper part
   // is already below the denominator, since the sum never exceeds it.
   always_comb begin : seed
      logic [NUM_W-1:0] num;
      div_in.valid = mix.valid;
      div_in.den   = mix.den;
      for (int l = 0; l < LANES; l++) begin
         num            = NUM_W'(mix.s_pos[l]) * NUM_W'(span);
         div_in.rem[l]  = MAG_W'(num[NUM_W-1:Q_W]);
         div_in.work[l] = num[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
      end else begin
         div_ff <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

### sv/qxmm_div_stage.sv
`timescale 1ns / 1ps

module qxmm_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  qxmm_pkg::div_type div_prev,
   output qxmm_pkg::div_type div_next
);
   import qxmm_pkg::*;

   div_type stage_in;
   div_type stage_ff;

   // Restoring division steps: shift in one numerator bit, subtract the
   // denominator where it fits, shift the quotient bit in at the bottom.
   always_comb begin : steps
      logic [MAG_W:0] trial;
      logic           q_bit;
      stage_in = div_prev;
      for (int l = 0; l < LANES; l++) begin
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            trial = {stage_in.rem[l], stage_in.work[l][Q_W-1]};
            q_bit = (trial >= {1'b0, stage_in.den});
            if (q_bit) begin
               trial = trial - {1'b0, stage_in.den};
            end
            stage_in.rem[l]  = trial[MAG_W-1:0];
            stage_in.work[l] = {stage_in.work[l][Q_W-2:0], q_bit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign div_next = stage_ff;

endmodule

### sv/quad_x_motor_mixer_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// command   start, busy, req_data                   taken when start and !busy
// result    rsp_strobe, rsp_data                    one cycle per item, no hold-off
// config    csr_valid, csr_ready, csr_index,        written when valid and ready
//           csr_wdata
//
// One item is accepted every cycle outside reset; each result passes through
// the sum, maximum and multiply stages, the quotient pipeline of eight stages
// of two bits each, and one output register. Reset clears every valid bit and
// loads the limits 1000 and 2000; busy is high only during reset. Nothing
// stalls, as the receiver takes every result.

module quad_x_motor_mixer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  qxmm_pkg::req_type                req_data,
   output logic                             rsp_strobe,
   output qxmm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qxmm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qxmm_pkg::CODE_W-1:0]      csr_wdata
);
   import qxmm_pkg::*;

   cfg_type                     cfg;
   mix_type                     mix;
   div_type                     div_chain [DIV_STAGES+1];
   div_type                     div_last;
   logic [LANES-1:0][CODE_W-1:0] code;
   logic                        strobe_in;
   logic                        strobe_ff;
   rsp_type                     rsp_in;
   rsp_type                     rsp_ff;

   assign busy = reset;

   qxmm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qxmm_mixer u_mixer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .req_data (req_data),
      .mix      (mix)
   );

   qxmm_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .mix     (mix),
      .div_out (div_chain[0])
   );

   // Quotient pipeline.
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      qxmm_div_stage u_div_stage (
         .clock    (clock),
         .reset    (reset),
         .div_prev (div_chain[g]),
         .div_next (div_chain[g+1])
      );
   end

   assign div_last = div_chain[DIV_STAGES];

   // Place the quotient between the limits; a falling range rounds the
   // quotient up so that the code is still floored.
   always_comb begin : place
      logic            falling;
      logic [CODE_W:0] q_fin;
      falling = cfg.output_maximum < cfg.output_minimum;
      for (int l = 0; l < LANES; l++) begin
         q_fin = {1'b0, div_last.work[l]};
         if (falling && (div_last.rem[l] != '0)) begin
            q_fin = q_fin + (CODE_W+1)'(1);
         end
         if (falling) begin
            code[l] = cfg.output_minimum - q_fin[CODE_W-1:0];
         end else begin
            code[l] = cfg.output_minimum + q_fin[CODE_W-1:0];
         end
      end
      rsp_in.motor_front_right = code[LANE_FRONT_RIGHT];
      rsp_in.motor_front_left  = code[LANE_FRONT_LEFT];
      rsp_in.motor_rear_left   = code[LANE_REAR_LEFT];
      rsp_in.motor_rear_right  = code[LANE_REAR_RIGHT];
      strobe_in                = div_last.valid;
   end

   // Output register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### sv/qxmm_checker.sv
`timescale 1ns / 1ps

module qxmm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input qxmm_pkg::req_type                req_data,
   input logic                             rsp_strobe,
   input qxmm_pkg::rsp_type                rsp_data,
   input logic                             csr_valid,
   input logic                             csr_ready
);
   import qxmm_pkg::*;

   // Nothing comes out in the cycle after a reset cycle.
   assert property (@(posedge clock) $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   // Every accepted item is answered after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_strobe)
      else $error("accepted item not answered in time");

   // No result without an item accepted at the matching time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without an accepted item");

   // Pure throttle drives all four motors alike.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.roll_cmd == '0) && (req_data.pitch_cmd == '0)
       && (req_data.yaw_cmd == '0))
      |-> ##PIPE_LATENCY
      ((rsp_data.motor_front_right == rsp_data.motor_front_left)
       && (rsp_data.motor_front_left == rsp_data.motor_rear_left)
       && (rsp_data.motor_rear_left == rsp_data.motor_rear_right)))
      else $error("unequal motors for throttle alone");

   // Configuration writes are taken outside reset.
   assert property (@(posedge clock) (csr_valid && !reset) |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind quad_x_motor_mixer_unit qxmm_checker u_checker (.*);
